@@ hdl/mhpq_pkg.sv @@
// Shared types and constants for the max-heap priority queue.
`timescale 1ns / 1ps
package mhpq_pkg;

  localparam int VALUE_W   = 32;
  localparam int CNT_OUT_W = 7;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CNT_OUT_W-1:0]      count_out_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic rd_up;     // read the parent of the hole
    logic up_move;   // parent drops into the hole, hole moves up
    logic rd_last;   // read the last entry
    logic cap_last;  // last entry becomes the moving value, hole at root
    logic rd_dn;     // read both children of the hole
    logic dn_move;   // larger child rises into the hole, hole moves down
    logic place;     // moving value written into the hole
    logic emit;      // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic last_one;
    logic at_root;
    logic up_go;
    logic leaf;
    logic dn_go;
    logic out_hold;
  } stat_t;

endpackage

@@ hdl/mhpq_if.sv @@
// Handshake channel interfaces for the heap input and result streams.
`timescale 1ns / 1ps
interface mhpq_in_if;
  logic                valid;
  logic                ready;
  logic                operation;
  mhpq_pkg::value_t    new_value;

  modport source (output valid, output operation, output new_value, input ready);
  modport sink   (input valid, input operation, input new_value, output ready);
endinterface

interface mhpq_out_if;
  logic                  valid;
  logic                  ready;
  mhpq_pkg::value_t      top_value;
  mhpq_pkg::count_out_t  entry_count;
  logic                  is_empty;
  logic                  op_error;

  modport source (output valid, output top_value, output entry_count, output is_empty,
                  output op_error, input ready);
  modport sink   (input valid, input top_value, input entry_count, input is_empty,
                  input op_error, output ready);
endinterface

@@ hdl/mhpq_ram.sv @@
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

@@ hdl/mhpq_ctrl.sv @@
// Sequencer for insert sift-up and delete sift-down.
`timescale 1ns / 1ps
module mhpq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_operation,
  input  mhpq_pkg::stat_t stat,
  output logic            in_ready,
  output mhpq_pkg::cmd_t  cmd
);
  import mhpq_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_RD   = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_DN_LAST = 3'd3;
  localparam logic [2:0] S_DN_LOAD = 3'd4;
  localparam logic [2:0] S_DN_RD   = 3'd5;
  localparam logic [2:0] S_DN_CMP  = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_operation == OP_INSERT) begin
            state_nxt = stat.full ? S_FIN : S_UP_RD;
          end else begin
            state_nxt = (stat.empty || stat.last_one) ? S_FIN : S_DN_LAST;
          end
        end
      end
      S_UP_RD: begin
        if (stat.at_root) begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.rd_up = 1'b1;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_go) begin
          cmd.up_move = 1'b1;
          state_nxt   = S_UP_RD;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_DN_LAST: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_DN_LOAD;
      end
      S_DN_LOAD: begin
        cmd.cap_last = 1'b1;
        state_nxt    = S_DN_RD;
      end
      S_DN_RD: begin
        if (stat.leaf) begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.rd_dn = 1'b1;
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (stat.dn_go) begin
          cmd.dn_move = 1'b1;
          state_nxt   = S_DN_RD;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!stat.out_hold) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/mhpq_dpath.sv @@
// Heap datapath: store, fill count, hole position, moving value, result register.
`timescale 1ns / 1ps
module mhpq_dpath #(
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mhpq_pkg::cmd_t       cmd,
  input  logic                 in_operation,
  input  mhpq_pkg::value_t     in_new_value,
  input  logic                 out_ready,
  output mhpq_pkg::stat_t      stat,
  output logic                 out_valid,
  output mhpq_pkg::value_t     out_top_value,
  output mhpq_pkg::count_out_t out_entry_count,
  output logic                 out_is_empty,
  output logic                 out_op_error
);
  import mhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;  // child index width, holds 2*pos+2

  logic [CW-1:0] fill_r;
  logic [AW-1:0] pos_r;
  value_t        val_r;
  value_t        root_r;
  logic          err_r;

  logic       out_valid_r;
  value_t     out_top_r;
  count_out_t out_cnt_r;
  logic       out_empty_r;
  logic       out_err_r;

  logic          we;
  logic [AW-1:0] waddr, raddr0, raddr1, parent;
  value_t        wdata;
  logic [VALUE_W-1:0] rdata0_raw, rdata1_raw;
  value_t        rd0, rd1;
  logic [IW-1:0] lidx, ridx, fill_ext;
  logic          lvalid, rvalid, go_left, go_right;

  mhpq_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0_raw),
    .rdata1 (rdata1_raw)
  );

  assign rd0      = $signed(rdata0_raw);
  assign rd1      = $signed(rdata1_raw);
  assign parent   = (pos_r - AW'(1)) >> 1;
  assign lidx     = {1'b0, pos_r, 1'b1};
  assign ridx     = lidx + IW'(1);
  assign fill_ext = IW'(fill_r);
  assign lvalid   = lidx < fill_ext;
  assign rvalid   = ridx < fill_ext;

  // Hole holds val_r; right wins only if strictly above whichever is best so far
  assign go_left  = lvalid && (rd0 > val_r);
  assign go_right = rvalid && (go_left ? (rd1 > rd0) : (rd1 > val_r));

  assign stat.full     = (fill_r == CW'(CAPACITY));
  assign stat.empty    = (fill_r == '0);
  assign stat.last_one = (fill_r == CW'(1));
  assign stat.at_root  = (pos_r == '0);
  assign stat.up_go    = (val_r > rd0);
  assign stat.leaf     = !lvalid;
  assign stat.dn_go    = go_left || go_right;
  assign stat.out_hold = out_valid_r && !out_ready;

  always_comb begin
    priority if (cmd.rd_dn) begin
      raddr0 = lidx[AW-1:0];
    end else if (cmd.rd_last) begin
      raddr0 = fill_r[AW-1:0];
    end else if (cmd.rd_up) begin
      raddr0 = parent;
    end else begin
      raddr0 = '0;
    end
    raddr1 = ridx[AW-1:0];
    waddr  = pos_r;
    we     = cmd.place || cmd.up_move || cmd.dn_move;
    priority if (cmd.up_move) begin
      wdata = rd0;
    end else if (cmd.dn_move) begin
      wdata = go_right ? rd1 : rd0;
    end else begin
      wdata = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (in_operation == OP_INSERT) begin
          err_r <= stat.full;
          if (!stat.full) begin
            fill_r <= fill_r + CW'(1);
          end
        end else begin
          err_r <= stat.empty;
          if (!stat.empty) begin
            fill_r <= fill_r - CW'(1);
          end
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_r <= in_new_value;
      pos_r <= fill_r[AW-1:0];
    end
    if (cmd.up_move) begin
      pos_r <= parent;
    end
    if (cmd.cap_last) begin
      val_r <= rd0;
      pos_r <= '0;
    end
    if (cmd.dn_move) begin
      pos_r <= go_right ? ridx[AW-1:0] : lidx[AW-1:0];
    end
    // shadow copy of the root entry
    if (we && (waddr == '0)) begin
      root_r <= wdata;
    end
    if (cmd.emit) begin
      out_top_r   <= stat.empty ? value_t'(0) : root_r;
      out_cnt_r   <= CNT_OUT_W'(fill_r);
      out_empty_r <= stat.empty;
      out_err_r   <= err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_top_value   = out_top_r;
  assign out_entry_count = out_cnt_r;
  assign out_is_empty    = out_empty_r;
  assign out_op_error    = out_err_r;

endmodule

@@ hdl/max_heap_priority_queue.sv @@
// Top level of the binary max-heap priority queue.
//
//   channel  dir  beat contents
//   in_ch    in   operation (0 insert, 1 delete max), new_value
//   out_ch   out  top_value, entry_count, is_empty, op_error
//
// One item at a time; the next is accepted once the current one is finished.
// Insert: the new value climbs level by level until its parent is not smaller
// or it reaches the root. Delete: the last entry is read and moved to the root,
// then sinks level by level until no child is larger or it reaches a leaf; a
// refused or final-entry item goes straight to the result. Each level takes one
// registered store read and then a compare/write step (six levels up or five down for 64 entries).
// Synchronous active-low reset empties the heap; no clearing pass is needed.
// A waiting result does not block acceptance of the next item; the sequencer
// holds only if a new result is ready before the previous one is taken.
`timescale 1ns / 1ps
module max_heap_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  mhpq_in_if.sink    in_ch,
  mhpq_out_if.source out_ch
);
  import mhpq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mhpq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .stat         (stat),
    .in_ready     (in_ch.ready),
    .cmd          (cmd)
  );

  mhpq_dpath #(.CAPACITY(CAPACITY)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_operation    (in_ch.operation),
    .in_new_value    (in_ch.new_value),
    .out_ready       (out_ch.ready),
    .stat            (stat),
    .out_valid       (out_ch.valid),
    .out_top_value   (out_ch.top_value),
    .out_entry_count (out_ch.entry_count),
    .out_is_empty    (out_ch.is_empty),
    .out_op_error    (out_ch.op_error)
  );

endmodule
